FILE: src/qdpr_pkg.sv
// shared widths, register indexes, reset values and configuration structs
// for the quantized dot product with requantization; no dependencies
package qdpr_pkg;

   // payload and register widths
   localparam int VALUE_WIDTH     = 9;
   localparam int SUM_WIDTH       = 32;
   localparam int MULT_WIDTH      = 31;
   localparam int SHIFT_WIDTH     = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 31;

   // default depth of the queue between the accumulator and the requantizer
   localparam int QUEUE_DEPTH = 4;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INPUT_OFFSET  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WEIGHT_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUTPUT_OFFSET = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MULTIPLIER    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHIFT         = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CLAMP_LOW     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CLAMP_HIGH    = 3'd6;

   // reset values
   localparam logic [MULT_WIDTH-1:0]         RESET_MULTIPLIER = 31'd1073741824;
   localparam logic signed [VALUE_WIDTH-1:0] RESET_CLAMP_LOW  = -9'sd128;
   localparam logic signed [VALUE_WIDTH-1:0] RESET_CLAMP_HIGH = 9'sd127;

   // settings used by the accumulator
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] act_offset;
      logic signed [VALUE_WIDTH-1:0] weight_offset;
   } front_cfg_type;

   // settings used by the requantizer
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] out_offset;
      logic [MULT_WIDTH-1:0]         requant_multiplier;
      logic signed [SHIFT_WIDTH-1:0] requant_shift;
      logic signed [VALUE_WIDTH-1:0] clamp_low;
      logic signed [VALUE_WIDTH-1:0] clamp_high;
   } back_cfg_type;

endpackage

FILE: src/quantized_dot_product_requantize.sv
// top level of the quantized dot product with requantization: register file,
// accumulator front end, row sum queue and requantizer; depends on qdpr_pkg
//
// Usage
//   Input transactions carry one activation, one weight, the row bias and a
//   last-of-row flag; one is taken on each edge with req_push high and req_full
//   low. Each element's offset product goes into a wrapping 32-bit accumulator.
//   The element flagged last also adds the bias, sends the row sum on and clears
//   the accumulator. Result transactions (one per row) appear on rsp_output_value
//   while rsp_empty is low and leave on an edge with rsp_pop high. The user
//   writes registers (csr_we/csr_index/csr_wdata) only while idle; not enforced.
// Timing
//   The accumulator takes one element per cycle while req_full is low. The
//   requantizer works on one row at a time (shift, 32x32 multiply, nudge,
//   rounding shift, clamp) and takes the next row sum only once the last
//   result is loaded; row sums that arrive faster wait in the row sum queue
//   (QUEUE_DEPTH entries) before req_full rises.
// Reset and stalls
//   Reset clears the accumulator, the queue and the output valid flag and loads
//   the register defaults. While a result waits, input keeps flowing until the
//   queue fills; then req_full holds back input while a row end waits for it.
module quantized_dot_product_requantize #(
   parameter int QUEUE_DEPTH = qdpr_pkg::QUEUE_DEPTH
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_push,
   output logic                                          req_full,
   input  logic signed [qdpr_pkg::VALUE_WIDTH-1:0]       req_input_value,
   input  logic signed [qdpr_pkg::VALUE_WIDTH-1:0]       req_weight_value,
   input  logic signed [qdpr_pkg::SUM_WIDTH-1:0]         req_row_bias,
   input  logic                                          req_last_of_row,
   output logic                                          rsp_empty,
   input  logic                                          rsp_pop,
   output logic signed [qdpr_pkg::VALUE_WIDTH-1:0]       rsp_output_value,
   input  logic                                          csr_we,
   input  logic [qdpr_pkg::CSR_INDEX_WIDTH-1:0]          csr_index,
   input  logic [qdpr_pkg::CSR_DATA_WIDTH-1:0]           csr_wdata
);
   import qdpr_pkg::*;

   front_cfg_type         front_cfg_ff, front_cfg_in;
   back_cfg_type          back_cfg_ff, back_cfg_in;
   logic                  q_push, q_full, q_pop, q_empty;
   logic [SUM_WIDTH-1:0]  q_wr_data, q_rd_data;

   // register writes
   always_comb begin
      front_cfg_in = front_cfg_ff;
      back_cfg_in  = back_cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_INPUT_OFFSET:  front_cfg_in.act_offset = csr_wdata[VALUE_WIDTH-1:0];
            REG_WEIGHT_OFFSET: front_cfg_in.weight_offset = csr_wdata[VALUE_WIDTH-1:0];
            REG_OUTPUT_OFFSET: back_cfg_in.out_offset = csr_wdata[VALUE_WIDTH-1:0];
            REG_MULTIPLIER:    back_cfg_in.requant_multiplier = csr_wdata[MULT_WIDTH-1:0];
            REG_SHIFT:         back_cfg_in.requant_shift = csr_wdata[SHIFT_WIDTH-1:0];
            REG_CLAMP_LOW:     back_cfg_in.clamp_low = csr_wdata[VALUE_WIDTH-1:0];
            REG_CLAMP_HIGH:    back_cfg_in.clamp_high = csr_wdata[VALUE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cfg_ff.act_offset       <= '0;
         front_cfg_ff.weight_offset    <= '0;
         back_cfg_ff.out_offset        <= '0;
         back_cfg_ff.requant_multiplier <= RESET_MULTIPLIER;
         back_cfg_ff.requant_shift     <= '0;
         back_cfg_ff.clamp_low         <= RESET_CLAMP_LOW;
         back_cfg_ff.clamp_high        <= RESET_CLAMP_HIGH;
      end else begin
         front_cfg_ff <= front_cfg_in;
         back_cfg_ff  <= back_cfg_in;
      end
   end

   // accumulator front end
   qdpr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (front_cfg_ff),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_input_value  (req_input_value),
      .req_weight_value (req_weight_value),
      .req_row_bias     (req_row_bias),
      .req_last_of_row  (req_last_of_row),
      .q_push           (q_push),
      .q_data           (q_wr_data),
      .q_full           (q_full)
   );

   // row sum queue
   qdpr_fifo #(
      .WIDTH (SUM_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   // requantizer back end
   qdpr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (back_cfg_ff),
      .q_empty          (q_empty),
      .q_data           (q_rd_data),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_output_value (rsp_output_value)
   );

   // a row sum is never offered to a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("row sum pushed into full queue");

   // the requantizer only takes a row sum that is there
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("requantizer popped empty queue");

   // nothing to deliver straight after reset
   assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result present after reset");

   // with ordered bounds every delivered value lies inside them
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (back_cfg_ff.clamp_low <= back_cfg_ff.clamp_high)) |->
      ((rsp_output_value >= back_cfg_ff.clamp_low) &&
       (rsp_output_value <= back_cfg_ff.clamp_high)))
      else $error("result outside clamp range");

endmodule

FILE: src/qdpr_front.sv
// accumulator front end: offsets, multiplies and accumulates each element,
// hands the biased row sum to the queue; depends on qdpr_pkg
module qdpr_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  qdpr_pkg::front_cfg_type                  cfg,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic signed [qdpr_pkg::VALUE_WIDTH-1:0]  req_input_value,
   input  logic signed [qdpr_pkg::VALUE_WIDTH-1:0]  req_weight_value,
   input  logic signed [qdpr_pkg::SUM_WIDTH-1:0]    req_row_bias,
   input  logic                                     req_last_of_row,
   output logic                                     q_push,
   output logic [qdpr_pkg::SUM_WIDTH-1:0]           q_data,
   input  logic                                     q_full
);
   import qdpr_pkg::*;

   localparam int OPND_WIDTH = VALUE_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * OPND_WIDTH;

   logic signed [OPND_WIDTH-1:0] x_opnd;
   logic signed [OPND_WIDTH-1:0] w_opnd;
   logic signed [PROD_WIDTH-1:0] prod;

   logic                         p_valid_ff, p_valid_in;
   logic                         p_last_ff;
   logic signed [PROD_WIDTH-1:0] p_prod_ff;
   logic [SUM_WIDTH-1:0]         p_bias_ff;
   logic [SUM_WIDTH-1:0]         acc_ff, acc_in;
   logic [SUM_WIDTH-1:0]         sum;
   logic                         advance;
   logic                         accept;

   // offset operands and their product
   assign x_opnd = OPND_WIDTH'(req_input_value) + OPND_WIDTH'(cfg.act_offset);
   assign w_opnd = OPND_WIDTH'(req_weight_value) + OPND_WIDTH'(cfg.weight_offset);
   assign prod   = PROD_WIDTH'(x_opnd) * PROD_WIDTH'(w_opnd);

   // the product stage only waits when it holds a row end and the queue is full
   assign advance  = !p_valid_ff || !p_last_ff || !q_full;
   assign req_full = !advance;
   assign accept   = req_push && advance;

   // accumulate, wrapping at 32 bits
   assign sum    = acc_ff + SUM_WIDTH'(p_prod_ff);
   assign q_push = p_valid_ff && p_last_ff && advance;
   assign q_data = sum + p_bias_ff;

   always_comb begin
      acc_in = acc_ff;
      if (p_valid_ff && advance) begin
         acc_in = p_last_ff ? '0 : sum;
      end
   end

   assign p_valid_in = advance ? accept : p_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         acc_ff     <= '0;
      end else begin
         p_valid_ff <= p_valid_in;
         acc_ff     <= acc_in;
      end
   end

   // product stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         p_prod_ff <= prod;
         p_last_ff <= req_last_of_row;
         p_bias_ff <= req_row_bias;
      end
   end

endmodule

FILE: src/qdpr_fifo.sv
// small register queue of row sums between accumulator and requantizer;
// standalone, no package use
module qdpr_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: src/qdpr_back.sv
// requantizer back end: shift, rounding doubling high multiply, rounding
// right shift, output offset and clamp, one row sum at a time; depends on qdpr_pkg
module qdpr_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  qdpr_pkg::back_cfg_type                   cfg,
   input  logic                                     q_empty,
   input  logic [qdpr_pkg::SUM_WIDTH-1:0]           q_data,
   output logic                                     q_pop,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic signed [qdpr_pkg::VALUE_WIDTH-1:0]  rsp_output_value
);
   import qdpr_pkg::*;

   localparam int PROD_WIDTH  = 2 * SUM_WIDTH;
   localparam int XW          = SUM_WIDTH + 1;
   localparam int CLAMP_WIDTH = SUM_WIDTH + 2;
   localparam logic [PROD_WIDTH-1:0] NUDGE = PROD_WIDTH'(64'd1 << 30);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_NUDGE = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_CLAMP = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic signed [SUM_WIDTH-1:0]   a_ff;
   logic signed [PROD_WIDTH-1:0]  prod_ff;
   logic signed [SUM_WIDTH-1:0]   hm_ff;
   logic signed [SUM_WIDTH-1:0]   rnd_ff;
   logic                          out_valid_ff, out_valid_in;
   logic signed [VALUE_WIDTH-1:0] out_value_ff;

   logic [4:0]                    left_amt;
   logic [SHIFT_WIDTH-1:0]        right_amt;
   logic signed [PROD_WIDTH-1:0]  prod;
   logic [PROD_WIDTH-1:0]         nudged;
   logic signed [XW-1:0]          x_ext;
   logic signed [XW-1:0]          q_shift;
   logic [XW-1:0]                 mask;
   logic [XW-1:0]                 rem;
   logic [XW-1:0]                 thr;
   logic signed [SUM_WIDTH-1:0]   rnd;
   logic signed [CLAMP_WIDTH-1:0] v_sum;
   logic signed [CLAMP_WIDTH-1:0] v_lo;
   logic signed [CLAMP_WIDTH-1:0] lo_ext;
   logic signed [CLAMP_WIDTH-1:0] hi_ext;
   logic signed [CLAMP_WIDTH-1:0] v_clamp;
   logic                          load_out;

   // shift decode: positive shifts left, otherwise a rounding right shift
   assign left_amt  = (cfg.requant_shift > 0) ? cfg.requant_shift[4:0] : 5'd0;
   assign right_amt = (cfg.requant_shift > 0) ? '0 : SHIFT_WIDTH'(-cfg.requant_shift);

   // signed accumulator times non-negative multiplier
   assign prod = PROD_WIDTH'(a_ff) * PROD_WIDTH'($signed({1'b0, cfg.requant_multiplier}));

   // nudge and divide by 2^31 rounding down: floor((p + 2^30) / 2^31) in both signs
   assign nudged = prod_ff + NUDGE;

   // rounding right shift, half away from zero
   assign x_ext   = XW'(hm_ff);
   assign q_shift = x_ext >>> right_amt;
   assign mask    = (XW'(1) << right_amt) - XW'(1);
   assign rem     = x_ext & mask;
   assign thr     = (mask >> 1) + XW'(hm_ff[SUM_WIDTH-1]);
   assign rnd     = q_shift[SUM_WIDTH-1:0] + SUM_WIDTH'(rem > thr);

   // output offset, then raise to the low bound and lower to the high bound
   assign v_sum   = CLAMP_WIDTH'(rnd_ff) + CLAMP_WIDTH'(cfg.out_offset);
   assign lo_ext  = CLAMP_WIDTH'(cfg.clamp_low);
   assign hi_ext  = CLAMP_WIDTH'(cfg.clamp_high);
   assign v_lo    = (v_sum < lo_ext) ? lo_ext : v_sum;
   assign v_clamp = (v_lo > hi_ext) ? hi_ext : v_lo;

   // handshakes
   assign q_pop        = (state_ff == ST_IDLE) && !q_empty;
   assign load_out     = (state_ff == ST_CLAMP) && (!out_valid_ff || rsp_pop);
   assign out_valid_in = load_out || (out_valid_ff && !rsp_pop);
   assign rsp_empty        = !out_valid_ff;
   assign rsp_output_value = out_value_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_NUDGE;
         ST_NUDGE: state_in = ST_ROUND;
         ST_ROUND: state_in = ST_CLAMP;
         ST_CLAMP: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_ff <= q_data << left_amt;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= prod;
      end
      if (state_ff == ST_NUDGE) begin
         hm_ff <= nudged[62:31];
      end
      if (state_ff == ST_ROUND) begin
         rnd_ff <= rnd;
      end
      if (load_out) begin
         out_value_ff <= v_clamp[VALUE_WIDTH-1:0];
      end
   end

endmodule

FILE: tb/quantized_dot_product_requantize_tb.sv
// self-checking testbench for quantized_dot_product_requantize: random and directed
// rows of activation/weight transactions, checked against a row requantize predictor
// depends on qdpr_pkg and the quantized_dot_product_requantize rtl
module quantized_dot_product_requantize_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qdpr_pkg::*;

   localparam int QUIET_LIMIT       = 2000;
   localparam int SETTLE_CYCLES     = 16;
   localparam int HOLD_OFF_CYCLES   = 300;
   localparam int SEGMENTS          = 6;
   localparam int ITEMS_PER_SEGMENT = 80;
   localparam int MAX_REPORTED      = 10;

   // index with no register behind it, writes there must change nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INDEX_SPARE = 3'd7;

   // one input transaction
   typedef struct {
      logic signed [VALUE_WIDTH-1:0] input_value;
      logic signed [VALUE_WIDTH-1:0] weight_value;
      logic signed [SUM_WIDTH-1:0]   row_bias;
      logic                          last_of_row;
   } element_type;

   // full register set of the layer
   typedef struct {
      front_cfg_type front;
      back_cfg_type  back;
   } layer_cfg_type;

   // predictor of the row requantize path and store of awaited outputs
   class row_output_scoreboard;
      front_cfg_type           front;
      back_cfg_type            back;
      logic [SUM_WIDTH-1:0]    row_sum;
      logic [VALUE_WIDTH-1:0]  pending_outputs[$];
      int                      mismatch_count;

      function new();
         front.act_offset         = '0;
         front.weight_offset      = '0;
         back.out_offset          = '0;
         back.requant_multiplier  = RESET_MULTIPLIER;
         back.requant_shift       = '0;
         back.clamp_low           = RESET_CLAMP_LOW;
         back.clamp_high          = RESET_CLAMP_HIGH;
         row_sum                  = '0;
         mismatch_count           = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] index,
                              logic [CSR_DATA_WIDTH-1:0] data);
         case (index)
            REG_INPUT_OFFSET:  front.act_offset        = data[VALUE_WIDTH-1:0];
            REG_WEIGHT_OFFSET: front.weight_offset     = data[VALUE_WIDTH-1:0];
            REG_OUTPUT_OFFSET: back.out_offset         = data[VALUE_WIDTH-1:0];
            REG_MULTIPLIER:    back.requant_multiplier = data[MULT_WIDTH-1:0];
            REG_SHIFT:         back.requant_shift      = data[SHIFT_WIDTH-1:0];
            REG_CLAMP_LOW:     back.clamp_low          = data[VALUE_WIDTH-1:0];
            REG_CLAMP_HIGH:    back.clamp_high         = data[VALUE_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // scale, round and clamp a finished row sum
      function logic [VALUE_WIDTH-1:0] requantize_sum(logic [SUM_WIDTH-1:0] acc);
         logic [SUM_WIDTH-1:0] scaled;
         longint a, m, prod, mask, rem, thr, v, lo, hi;
         int sh, left, right;
         sh    = int'(back.requant_shift);
         left  = (sh > 0) ? sh : 0;
         right = (sh > 0) ? 0 : -sh;
         scaled = acc << left;
         a = longint'($signed(scaled));
         m = longint'(back.requant_multiplier);
         // doubling high multiply, the multiplier is never negative so no saturation
         prod = a * m;
         prod = prod + ((prod >= 0) ? (longint'(1) << 30)
                                    : (longint'(1) - (longint'(1) << 30)));
         prod = prod / (longint'(1) << 31);
         // right shift with rounding half away from zero
         if (right > 0) begin
            mask = (longint'(1) << right) - 1;
            rem  = prod & mask;
            thr  = (mask >>> 1) + ((prod < 0) ? 1 : 0);
            prod = (prod >>> right) + ((rem > thr) ? 1 : 0);
         end
         v  = prod + longint'($signed(back.out_offset));
         lo = longint'($signed(back.clamp_low));
         hi = longint'($signed(back.clamp_high));
         if (v < lo) v = lo;
         if (v > hi) v = hi;
         return v[VALUE_WIDTH-1:0];
      endfunction

      // accumulate one accepted element, close the row on its last element
      function void note_element(element_type e);
         longint act, wgt;
         act = longint'(e.input_value) + longint'($signed(front.act_offset));
         wgt = longint'(e.weight_value) + longint'($signed(front.weight_offset));
         row_sum = row_sum + 32'(act * wgt);
         if (e.last_of_row) begin
            row_sum = row_sum + e.row_bias;
            pending_outputs.push_back(requantize_sum(row_sum));
            row_sum = '0;
         end
      endfunction

      function void check_output(logic [VALUE_WIDTH-1:0] actual);
         logic [VALUE_WIDTH-1:0] want;
         if (pending_outputs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
               $display("unexpected result: output_value %0d with nothing expected",
                        $signed(actual));
         end else begin
            want = pending_outputs.pop_front();
            if (actual !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED)
                  $display("mismatch: output_value expected %0d, got %0d",
                           $signed(want), $signed(actual));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [VALUE_WIDTH-1:0] req_input_value  = '0;
   logic signed [VALUE_WIDTH-1:0] req_weight_value = '0;
   logic signed [SUM_WIDTH-1:0]   req_row_bias     = '0;
   logic req_last_of_row = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [VALUE_WIDTH-1:0] rsp_output_value;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int send_idle_pct   = 35;
   int pop_idle_pct    = 61;
   int pop_hold_cycles = 0;
   int quiet_cycles    = 0;

   row_output_scoreboard sb = new();

   quantized_dot_product_requantize u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_input_value  (req_input_value),
      .req_weight_value (req_weight_value),
      .req_row_bias     (req_row_bias),
      .req_last_of_row  (req_last_of_row),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_output_value (rsp_output_value),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // watch both channels, feed the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (req_push && !req_full) begin
            sb.note_element('{req_input_value, req_weight_value, req_row_bias,
                              req_last_of_row});
            quiet_cycles = 0;
         end
         if (rsp_pop && !rsp_empty) begin
            sb.check_output(rsp_output_value);
            quiet_cycles = 0;
         end
      end
   end

   // watchdog on a stuck handshake
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // result side: random pops, with one long hold-off on request
   initial begin
      forever begin
         if (pop_hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (pop_hold_cycles) @(posedge clock);
            pop_hold_cycles = 0;
         end
         rsp_pop <= ($urandom_range(0, 99) >= pop_idle_pct);
         @(posedge clock);
      end
   end

   function automatic element_type make_element(int iv, int wv, logic [31:0] bias,
                                                int last);
      element_type e;
      e.input_value  = VALUE_WIDTH'(iv);
      e.weight_value = VALUE_WIDTH'(wv);
      e.row_bias     = bias;
      e.last_of_row  = (last != 0);
      return e;
   endfunction

   // random element, raw ones use every bit of the fields
   function automatic element_type random_element(bit last, bit raw);
      element_type e;
      if (raw) begin
         e.input_value  = VALUE_WIDTH'($urandom_range(0, 511));
         e.weight_value = VALUE_WIDTH'($urandom_range(0, 511));
         e.row_bias     = $urandom;
      end else begin
         e.input_value  = VALUE_WIDTH'(int'($urandom_range(0, 383)) - 128);
         e.weight_value = VALUE_WIDTH'(int'($urandom_range(0, 383)) - 128);
         if ($urandom_range(0, 9) < 7)
            e.row_bias = int'($urandom_range(0, 131072)) - 65536;
         else
            e.row_bias = $urandom;
      end
      e.last_of_row = last;
      return e;
   endfunction

   function automatic layer_cfg_type random_config(bit wild);
      layer_cfg_type c;
      int pick;
      if (wild) begin
         c.front.act_offset    = VALUE_WIDTH'($urandom_range(0, 511));
         c.front.weight_offset = VALUE_WIDTH'($urandom_range(0, 511));
         c.back.out_offset     = VALUE_WIDTH'($urandom_range(0, 511));
         pick = $urandom_range(0, 3);
         case (pick)
            0:       c.back.requant_multiplier = '0;
            1:       c.back.requant_multiplier = '1;
            default: c.back.requant_multiplier = MULT_WIDTH'($urandom);
         endcase
         c.back.requant_shift = SHIFT_WIDTH'($urandom_range(0, 63));
         c.back.clamp_low     = VALUE_WIDTH'($urandom_range(0, 511));
         c.back.clamp_high    = VALUE_WIDTH'($urandom_range(0, 511));
      end else begin
         c.front.act_offset        = VALUE_WIDTH'(int'($urandom_range(0, 383)) - 255);
         c.front.weight_offset     = VALUE_WIDTH'(int'($urandom_range(0, 383)) - 255);
         c.back.out_offset         = VALUE_WIDTH'(int'($urandom_range(0, 383)) - 128);
         c.back.requant_multiplier =
            MULT_WIDTH'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
         c.back.requant_shift      = SHIFT_WIDTH'(-int'($urandom_range(6, 16)));
         c.back.clamp_low          = VALUE_WIDTH'(int'($urandom_range(0, 128)) - 128);
         c.back.clamp_high         = VALUE_WIDTH'($urandom_range(0, 255));
      end
      return c;
   endfunction

   function automatic layer_cfg_type fixed_config(int in_off, int w_off, int out_off,
                                                  logic [30:0] mult, int shift,
                                                  int lo, int hi);
      layer_cfg_type c;
      c.front.act_offset        = VALUE_WIDTH'(in_off);
      c.front.weight_offset     = VALUE_WIDTH'(w_off);
      c.back.out_offset         = VALUE_WIDTH'(out_off);
      c.back.requant_multiplier = mult;
      c.back.requant_shift      = SHIFT_WIDTH'(shift);
      c.back.clamp_low          = VALUE_WIDTH'(lo);
      c.back.clamp_high         = VALUE_WIDTH'(hi);
      return c;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(index, data);
   endtask

   // write every register, upper data bits sometimes filled with junk
   task automatic apply_config(input layer_cfg_type c);
      logic [CSR_DATA_WIDTH-1:0] junk;
      junk = $urandom_range(0, 1) ? CSR_DATA_WIDTH'($urandom) : '0;
      write_csr(REG_INPUT_OFFSET,
                {junk[CSR_DATA_WIDTH-1:VALUE_WIDTH], c.front.act_offset});
      write_csr(REG_WEIGHT_OFFSET,
                {junk[CSR_DATA_WIDTH-1:VALUE_WIDTH], c.front.weight_offset});
      write_csr(REG_OUTPUT_OFFSET,
                {junk[CSR_DATA_WIDTH-1:VALUE_WIDTH], c.back.out_offset});
      write_csr(REG_MULTIPLIER, c.back.requant_multiplier);
      write_csr(REG_SHIFT, {junk[CSR_DATA_WIDTH-1:SHIFT_WIDTH], c.back.requant_shift});
      write_csr(REG_CLAMP_LOW,
                {junk[CSR_DATA_WIDTH-1:VALUE_WIDTH], c.back.clamp_low});
      write_csr(REG_CLAMP_HIGH,
                {junk[CSR_DATA_WIDTH-1:VALUE_WIDTH], c.back.clamp_high});
      write_csr(CSR_INDEX_SPARE, CSR_DATA_WIDTH'($urandom));
      csr_we <= 1'b0;
   endtask

   // offer one element, with random gaps, until the block takes it
   task automatic push_element(input element_type e);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_input_value  <= e.input_value;
      req_weight_value <= e.weight_value;
      req_row_bias     <= e.row_bias;
      req_last_of_row  <= e.last_of_row;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // stop offering, wait for every awaited output and for the pipeline to empty
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // whole rows of random length, mostly short, a few long, some raw
   task automatic run_rows(input int target_items);
      int sent, len, r;
      bit raw;
      sent = 0;
      while (sent < target_items) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            len = $urandom_range(1, 3);
         else if (r < 85)
            len = $urandom_range(4, 10);
         else
            len = $urandom_range(11, 40);
         raw = ($urandom_range(0, 99) < 15);
         for (int k = 0; k < len; k++)
            push_element(random_element(k == len - 1, raw));
         sent += len;
      end
   endtask

   // main sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults from reset: saturation, rounding and bias wrap
      push_element(make_element(255, 255, 0, 1));
      push_element(make_element(-128, 255, 0, 1));
      push_element(make_element(3, 5, 10, 1));
      push_element(make_element(-1, -1, 32'h1234_5678, 0));
      push_element(make_element(2, -3, 32'hFFFF_0000, 0));
      push_element(make_element(7, 7, -40, 1));
      push_element(make_element(-256, -256, 0, 1));
      push_element(make_element(1, 1, 32'h7FFF_FFFF, 1));
      push_element(make_element(0, 0, 32'h8000_0000, 1));
      push_element(make_element(0, 0, 32'hFFFF_FFFF, 1));
      settle();

      // largest left shift, so the scaled sum wraps
      apply_config(fixed_config(-255, 128, 255, 31'h7FFF_FFFF, 31, -256, 255));
      push_element(make_element(255, -128, 0, 1));
      push_element(make_element(-128, 255, 1, 1));
      push_element(make_element(0, 0, 32'hFFFF_FFFF, 1));
      push_element(make_element(1, 1, 0, 1));
      settle();

      // right shift by the full word
      apply_config(fixed_config(128, -255, -128, 31'h7FFF_FFFF, -32, -256, 255));
      push_element(make_element(255, 255, 32'h8000_0000, 1));
      push_element(make_element(0, 0, 32'h7FFF_FFFF, 1));
      push_element(make_element(-128, -128, 0, 1));
      settle();

      // clamp bounds crossed, the upper bound wins
      apply_config(fixed_config(0, 0, 0, 31'h4000_0000, 0, 100, -50));
      push_element(make_element(5, 5, 0, 1));
      push_element(make_element(-5, 5, 0, 1));
      settle();

      // random segments, idling swapped after the first two, then none, with a long hold-off
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 2)
            0: begin
               send_idle_pct = 35;
               pop_idle_pct  = 61;
            end
            1: begin
               send_idle_pct = 61;
               pop_idle_pct  = 35;
            end
            default: begin
               send_idle_pct = 0;
               pop_idle_pct  = 0;
            end
         endcase
         apply_config(random_config(seg % 2 == 1));
         if (seg == 4)
            pop_hold_cycles = HOLD_OFF_CYCLES;
         run_rows(ITEMS_PER_SEGMENT);
         settle();
      end

      if (sb.mismatch_count == 0 && sb.pending_outputs.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
